// File: hdl/load_limited_delay_line_admission_unit_macros.svh
// Assertion helpers for the admission unit.
`ifndef LOAD_LIMITED_DELAY_LINE_ADMISSION_UNIT_MACROS_SVH
`define LOAD_LIMITED_DELAY_LINE_ADMISSION_UNIT_MACROS_SVH

`ifndef SYNTH
// Clocked check, masked while in reset.
`define LLDA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define LLDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLDA_ASSERT(lbl, clk, rstn, prop, msg)
`define LLDA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/llda_pkg.sv
package llda_pkg;

    // register map, index = paddr / 4
    typedef enum logic {
        REG_SPAN  = 1'b0,
        REG_LIMIT = 1'b1
    } llda_reg_t;

    localparam int unsigned FIELD_W   = 16;  // weight / load / limit fields
    localparam int unsigned SPAN_IN_W = 11;  // span_length register field
    localparam int unsigned TICK_W    = 32;

    // control from the admission logic to every cell of the line
    typedef struct packed {
        logic shift;  // a tick: every cell takes its neighbour's slot
        logic clear;  // span rewritten: empty the line
    } llda_chain_ctl_t;

endpackage

// File: hdl/llda_cell.sv
module llda_cell
    import llda_pkg::*;
#(
    parameter int unsigned CW    = 16,
    parameter int unsigned IDX_W = 10,
    parameter int unsigned INDEX = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  llda_chain_ctl_t ctl,
    input  logic [IDX_W-1:0] start_idx,
    input  logic [CW-1:0]   entry,
    input  logic [CW-1:0]   prev,
    output logic [CW-1:0]   q
);

    logic [CW-1:0] q_reg;
    logic [CW-1:0] q_next;

    // the cell at the start of the line takes the new slot, the rest shift
    always_comb
    begin
        q_next = q_reg;
        if (ctl.clear)
        begin
            q_next = '0;
        end
        else if (ctl.shift)
        begin
            q_next = (start_idx == IDX_W'(INDEX)) ? entry : prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: hdl/llda_chain.sv
module llda_chain
    import llda_pkg::*;
#(
    parameter int unsigned MAX_SPAN = 1024,
    parameter int unsigned CW       = 16,
    parameter int unsigned IDX_W    = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  llda_chain_ctl_t  ctl,
    input  logic [IDX_W-1:0] start_idx,
    input  logic [CW-1:0]    entry,
    output logic [CW-1:0]    departed
);

    logic [CW-1:0] tap [MAX_SPAN];

    for (genvar i = 0; i < MAX_SPAN; i++)
    begin : g_cell
        logic [CW-1:0] prev_w;
        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_rest
            assign prev_w = tap[i-1];
        end

        llda_cell #(
            .CW    (CW),
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .start_idx (start_idx),
            .entry     (entry),
            .prev      (prev_w),
            .q         (tap[i])
        );
    end

    // last cell holds the oldest slot of the line
    assign departed = tap[MAX_SPAN-1];

endmodule

// File: hdl/load_limited_delay_line_admission_unit.sv
// Load-limited delay line admission unit. One request on the s_ side is one tick:
// the oldest slot of the line leaves (its weight is taken off the load), then the
// waiting item is admitted if load + weight <= load_limit, otherwise an empty slot
// goes in. An admitted item leaves span_length ticks later. One result per request
// appears on the m_ side, carrying admitted/oversize flags, departed weight, load
// after the tick, a saturating tick count and an empty flag. Throughput is one
// request per clock unless m_tready stalls the output; the result is registered and
// appears in the cycle after acceptance; s_tready stays high while a waiting result
// is being taken. The tick rate is set by the combinational subtract, add and
// compare on the running load. The line is a row of MAX_SPAN shift cells; new slots
// enter at cell MAX_SPAN - span_length and leave from the last cell, so no memory
// read port is involved. Writing span_length empties all cells at once (no clearing
// pass); the tick count is kept. load_limit takes effect at once. Registers:
// span_length at 0x0 (0 acts as 1, above MAX_SPAN acts as MAX_SPAN, reads back the
// effective value), load_limit at 0x4. Configure only while idle.
`include "load_limited_delay_line_admission_unit_macros.svh"

module load_limited_delay_line_admission_unit
    import llda_pkg::*;
#(
    parameter int unsigned MAX_SPAN    = 1024,
    parameter int unsigned WEIGHT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] item_waiting, [16:1] item_weight, [23:17] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] admitted, [1] oversize, [17:2] departed_weight,
                                   // [33:18] line_load, [65:34] elapsed_ticks,
                                   // [66] line_empty, [71:67] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // stored slot width; item_weight is carried at FIELD_W bits on the port
    localparam int unsigned CW     = (WEIGHT_BITS < FIELD_W) ? WEIGHT_BITS : FIELD_W;
    localparam int unsigned IDX_W  = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int unsigned SPAN_W = $clog2(MAX_SPAN + 1);

    // ---------------------------------------------------------------- config
    logic [SPAN_W-1:0]  span_reg;
    logic [IDX_W-1:0]   start_reg;    // MAX_SPAN - span: entry cell of the line
    logic [FIELD_W-1:0] limit_reg;

    logic                 cfg_wr;
    llda_reg_t            cfg_sel;
    logic [SPAN_IN_W-1:0] span_raw;
    logic [SPAN_W-1:0]    span_eff;
    logic                 span_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = llda_reg_t'(paddr[2]);
    assign span_wr = cfg_wr && (cfg_sel == REG_SPAN);
    assign span_raw = pwdata[SPAN_IN_W-1:0];

    // clamp span into 1 .. MAX_SPAN
    always_comb
    begin
        if (span_raw == '0)
        begin
            span_eff = SPAN_W'(1);
        end
        else if (32'(span_raw) > 32'(MAX_SPAN))
        begin
            span_eff = SPAN_W'(MAX_SPAN);
        end
        else
        begin
            span_eff = SPAN_W'(span_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg  <= SPAN_W'(1);
            start_reg <= IDX_W'(MAX_SPAN - 1);
            limit_reg <= '1;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_SPAN:
                begin
                    span_reg  <= span_eff;
                    start_reg <= IDX_W'(32'(MAX_SPAN) - 32'(span_eff));
                end
                REG_LIMIT:
                begin
                    limit_reg <= pwdata[FIELD_W-1:0];
                end
                default:
                begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_SPAN:  prdata = 32'(span_reg);
            REG_LIMIT: prdata = 32'(limit_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- handshake
    logic s_accept;
    logic out_valid_reg;
    logic out_valid_next;

    // output register frees up in the same cycle it is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------ delay line
    logic               item_waiting;
    logic [FIELD_W-1:0] item_weight;
    logic [CW-1:0]      weight_c;
    logic [CW-1:0]      entry;
    logic [CW-1:0]      departed_c;
    llda_chain_ctl_t    chain_ctl;

    assign item_waiting = s_tdata[0];
    assign item_weight  = s_tdata[FIELD_W:1];
    assign weight_c     = item_weight[CW-1:0];

    assign chain_ctl.shift = s_accept;
    assign chain_ctl.clear = span_wr;

    llda_chain #(
        .MAX_SPAN (MAX_SPAN),
        .CW       (CW),
        .IDX_W    (IDX_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (chain_ctl),
        .start_idx (start_reg),
        .entry     (entry),
        .departed  (departed_c)
    );

    // ------------------------------------------------------------- admission
    logic [FIELD_W-1:0] load_reg;
    logic [FIELD_W-1:0] load_next;
    logic [FIELD_W-1:0] dep_w;
    logic [FIELD_W-1:0] wt_w;
    logic [FIELD_W-1:0] load_rem;
    logic [FIELD_W:0]   load_sum;
    logic               admit;
    logic               over;

    assign dep_w = FIELD_W'(departed_c);
    assign wt_w  = FIELD_W'(weight_c);

    // departure first (floored at zero), then try to fit the waiting item
    assign load_rem = (dep_w <= load_reg) ? (load_reg - dep_w) : '0;
    assign load_sum = {1'b0, load_rem} + {1'b0, wt_w};
    assign admit    = item_waiting && (load_sum <= {1'b0, limit_reg});
    assign over     = item_waiting && (wt_w > limit_reg);
    assign entry    = admit ? weight_c : '0;

    always_comb
    begin
        load_next = load_reg;
        if (span_wr)
        begin
            load_next = '0;
        end
        else if (s_accept)
        begin
            load_next = admit ? load_sum[FIELD_W-1:0] : load_rem;
        end
    end

    // ----------------------------------------------------------- tick count
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;

    assign tick_next = (s_accept && (tick_reg != '1)) ? tick_reg + 1'b1 : tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
            tick_reg <= '0;
        end
        else
        begin
            load_reg <= load_next;
            tick_reg <= tick_next;
        end
    end

    // --------------------------------------------------------- result output
    logic [71:0] m_data_reg;

    assign out_valid_next = s_accept || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_data_reg <= {5'b0,
                           (load_next == '0),
                           tick_next,
                           load_next,
                           dep_w,
                           over,
                           admit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------ assertions
    `LLDA_ASSERT(a_result_follows, clk, rst_n, s_accept |=> m_tvalid, "accepted request gave no result")
    `LLDA_ASSERT(a_admit_fits, clk, rst_n, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "oversize item admitted")
    `LLDA_ASSERT(a_span_range, clk, rst_n, (span_reg != '0) && (32'(span_reg) <= 32'(MAX_SPAN)), "span out of range")
    `LLDA_ASSERT(a_tick_moves, clk, rst_n, s_accept |=> (tick_reg != '0), "tick count did not advance")
    `LLDA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !m_tvalid, "result valid in reset")

endmodule
